@@ rtl/core/srrd_pkg.sv @@
// Shared types, constants and helpers for the sparse row relative drop core.
// No dependencies; used by every module of the block but srrd_ram.
package srrd_pkg;

  localparam int MaxRowEntries = 64;
  localparam int ColumnBits    = 20;
  localparam int ValueBits     = 32;
  localparam int TolBits       = 16;
  localparam int MagBits       = 31;
  localparam int ThreshBits    = MagBits + TolBits;
  localparam int PtrBits       = 32;
  localparam int CfgDataBits   = 16;
  localparam int CfgIndexBits  = 1;

  typedef enum logic [CfgIndexBits-1:0] {
    CFG_DROP_TOL   = 1'b0,
    CFG_INDEX_BASE = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_THRESH,
    ST_COUNT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic thresh_load;
    logic scan_start;
    logic scan_step;
    logic count_en;
    logic count_commit;
    logic emit_en;
    logic row_clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic close_row;
    logic data_last;
  } dp_status_t;

  // |value| with the most negative code saturated to the largest positive one
  function automatic logic [MagBits-1:0] sat_mag(input logic [ValueBits-1:0] raw);
    logic [ValueBits-1:0] neg;
    neg = ~raw + ValueBits'(1);
    if (raw[ValueBits-1]) begin
      return neg[ValueBits-1] ? {MagBits{1'b1}} : neg[MagBits-1:0];
    end
    return raw[MagBits-1:0];
  endfunction

endpackage

@@ rtl/core/srrd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module srrd_ram #(
  parameter int WIDTH = 52,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/srrd_ctrl.sv @@
// Sequencer for the drop core: accept, threshold, count pass, emit pass.
// Depends on srrd_pkg.
module srrd_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  srrd_pkg::dp_status_t   status,
  output srrd_pkg::ctrl_cmd_t    cmd
);

  srrd_pkg::state_t state_r;
  srrd_pkg::state_t state_nxt;
  logic             accept;

  assign busy   = (state_r != srrd_pkg::ST_IDLE);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srrd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      srrd_pkg::ST_IDLE: begin
        if (accept && status.close_row) begin
          state_nxt = srrd_pkg::ST_THRESH;
        end
      end
      srrd_pkg::ST_THRESH: begin
        state_nxt = srrd_pkg::ST_COUNT;
      end
      srrd_pkg::ST_COUNT: begin
        if (status.data_last) begin
          state_nxt = srrd_pkg::ST_EMIT;
        end
      end
      srrd_pkg::ST_EMIT: begin
        if (status.data_last) begin
          state_nxt = srrd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = srrd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      srrd_pkg::ST_IDLE: begin
        cmd.accept = accept;
      end
      srrd_pkg::ST_THRESH: begin
        cmd.thresh_load = 1'b1;
        cmd.scan_start  = 1'b1;
      end
      srrd_pkg::ST_COUNT: begin
        cmd.scan_step = 1'b1;
        cmd.count_en  = 1'b1;
        if (status.data_last) begin
          cmd.count_commit = 1'b1;
          cmd.scan_start   = 1'b1; // rewind for the emit pass
        end
      end
      srrd_pkg::ST_EMIT: begin
        cmd.scan_step = 1'b1;
        cmd.emit_en   = 1'b1;
        if (status.data_last) begin
          cmd.row_clear = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

@@ rtl/core/srrd_datapath.sv @@
// Datapath of the drop core: row buffer, peak, threshold, counters, result register.
// Depends on srrd_pkg and srrd_ram.
module srrd_datapath #(
  parameter int MAX_ROW_ENTRIES = srrd_pkg::MaxRowEntries,
  parameter int COLUMN_BITS     = srrd_pkg::ColumnBits
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  srrd_pkg::ctrl_cmd_t                   cmd,
  output srrd_pkg::dp_status_t                  status,
  input  logic                                  cfg_we,
  input  logic [srrd_pkg::CfgIndexBits-1:0]     cfg_index,
  input  logic [srrd_pkg::CfgDataBits-1:0]      cfg_data,
  input  logic [COLUMN_BITS-1:0]                in_column_index,
  input  logic signed [srrd_pkg::ValueBits-1:0] in_entry_value,
  input  logic                                  in_has_entry,
  input  logic                                  in_row_end,
  output logic                                  out_strobe,
  output logic [COLUMN_BITS-1:0]                out_kept_column,
  output logic signed [srrd_pkg::ValueBits-1:0] out_kept_value,
  output logic                                  out_kept_valid,
  output logic                                  out_last_of_row,
  output logic [srrd_pkg::PtrBits-1:0]          out_row_end_pointer
);

  localparam int AddrW = $clog2(MAX_ROW_ENTRIES);
  localparam int FillW = $clog2(MAX_ROW_ENTRIES + 1);
  localparam int ValW  = srrd_pkg::ValueBits;
  localparam int RamW  = COLUMN_BITS + ValW;
  localparam int MagW  = srrd_pkg::MagBits;
  localparam int ThrW  = srrd_pkg::ThreshBits;
  localparam int TolW  = srrd_pkg::TolBits;
  localparam int PtrW  = srrd_pkg::PtrBits;

  logic [TolW-1:0]  tol_r;
  logic             base_r;
  logic [FillW-1:0] fill_r;
  logic [MagW-1:0]  peak_r;
  logic [ThrW-1:0]  thresh_r;
  logic [FillW-1:0] issue_r;
  logic             rd_vld_r;
  logic [FillW-1:0] rd_idx_r;
  logic [FillW-1:0] keep_cnt_r;
  logic [FillW-1:0] keep_cnt_nxt;
  logic [FillW-1:0] emit_cnt_r;
  logic [PtrW-1:0]  kept_total_r;
  logic [PtrW-1:0]  kept_total_nxt;

  logic                  out_strobe_r;
  logic [COLUMN_BITS-1:0] out_col_r;
  logic [ValW-1:0]       out_val_r;
  logic                  out_valid_r;
  logic                  out_last_r;
  logic [PtrW-1:0]       out_ptr_r;

  logic             fill_zero;
  logic             fill_full;
  logic             store;
  logic             marker;
  logic [MagW-1:0]  in_mag;
  logic             rd_en;
  logic [RamW-1:0]  rd_data;
  logic [ValW-1:0]  rd_val;
  logic [MagW-1:0]  rd_mag;
  logic             keep_hit;
  logic             emit_hit;
  logic [ThrW-1:0]  product;

  assign fill_zero = (fill_r == '0);
  assign fill_full = (fill_r == FillW'(MAX_ROW_ENTRIES));
  assign store     = cmd.accept && in_has_entry && !fill_full;
  assign marker    = cmd.accept && in_row_end && !in_has_entry && fill_zero;
  assign in_mag    = srrd_pkg::sat_mag(in_entry_value);

  assign status.close_row = in_row_end && (!fill_zero || in_has_entry);
  assign status.data_last = rd_vld_r && ((rd_idx_r + FillW'(1)) == fill_r);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r  <= '0;
      base_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (srrd_pkg::cfg_idx_t'(cfg_index))
        srrd_pkg::CFG_DROP_TOL:   tol_r  <= cfg_data[TolW-1:0];
        srrd_pkg::CFG_INDEX_BASE: base_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // row buffer: column and value side by side
  assign rd_en = cmd.scan_step && !cmd.scan_start && (issue_r < fill_r);

  srrd_ram #(
    .WIDTH (RamW),
    .DEPTH (MAX_ROW_ENTRIES)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (store),
    .wr_addr (fill_r[AddrW-1:0]),
    .wr_data ({in_column_index, in_entry_value}),
    .rd_en   (rd_en),
    .rd_addr (issue_r[AddrW-1:0]),
    .rd_data (rd_data)
  );

  assign rd_val   = rd_data[ValW-1:0];
  assign rd_mag   = srrd_pkg::sat_mag(rd_val);
  // Q15.16 magnitude shifted to Q15.32 against the exact Q15.32 threshold
  assign keep_hit = rd_vld_r && ({rd_mag, {TolW{1'b0}}} >= thresh_r);
  assign emit_hit = cmd.emit_en && keep_hit;
  assign product  = peak_r * tol_r;

  always_comb begin
    keep_cnt_nxt = keep_cnt_r;
    if (cmd.thresh_load) begin
      keep_cnt_nxt = '0;
    end else if (cmd.count_en && keep_hit) begin
      keep_cnt_nxt = keep_cnt_r + FillW'(1);
    end
  end

  assign kept_total_nxt = kept_total_r + PtrW'(keep_cnt_nxt);

  always_ff @(posedge clk) begin
    if (cmd.thresh_load) begin
      thresh_r <= product;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r       <= '0;
      peak_r       <= '0;
      issue_r      <= '0;
      rd_vld_r     <= 1'b0;
      rd_idx_r     <= '0;
      keep_cnt_r   <= '0;
      emit_cnt_r   <= '0;
      kept_total_r <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cmd.row_clear) begin
        fill_r <= '0;
        peak_r <= '0;
      end else if (store) begin
        fill_r <= fill_r + FillW'(1);
        if (in_mag > peak_r) begin
          peak_r <= in_mag;
        end
      end

      if (cmd.scan_start) begin
        issue_r <= '0;
      end else if (rd_en) begin
        issue_r <= issue_r + FillW'(1);
      end
      rd_vld_r <= rd_en;
      if (rd_en) begin
        rd_idx_r <= issue_r;
      end

      keep_cnt_r <= keep_cnt_nxt;
      if (cmd.count_commit) begin
        kept_total_r <= kept_total_nxt;
      end

      if (cmd.thresh_load) begin
        emit_cnt_r <= '0;
      end else if (emit_hit) begin
        emit_cnt_r <= emit_cnt_r + FillW'(1);
      end

      out_strobe_r <= marker || emit_hit;
    end
  end

  // result payload, loaded only on a strobed beat
  always_ff @(posedge clk) begin
    if (marker) begin
      out_col_r   <= '0;
      out_val_r   <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b1;
      out_ptr_r   <= kept_total_r + PtrW'(base_r);
    end else if (emit_hit) begin
      out_col_r   <= rd_data[RamW-1:ValW];
      out_val_r   <= rd_val;
      out_valid_r <= 1'b1;
      out_last_r  <= ((emit_cnt_r + FillW'(1)) == keep_cnt_r);
      out_ptr_r   <= kept_total_r + PtrW'(base_r);
    end
  end

  assign out_strobe          = out_strobe_r;
  assign out_kept_column     = out_col_r;
  assign out_kept_value      = out_val_r;
  assign out_kept_valid      = out_valid_r;
  assign out_last_of_row     = out_last_r;
  assign out_row_end_pointer = out_ptr_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FillW'(MAX_ROW_ENTRIES))
    else $error("row fill beyond buffer depth");

  a_peak_kept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.count_commit |-> keep_cnt_nxt != '0)
    else $error("closed row kept no entry");

  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    emit_hit |-> emit_cnt_r < keep_cnt_r)
    else $error("more entries emitted than counted");

  a_row_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.row_clear |=> fill_r == '0 && peak_r == '0)
    else $error("row state not cleared");

  // the final kept entry may sit anywhere in the row, so check counts at the clear
  a_all_emitted: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.row_clear |-> (emit_cnt_r + FillW'(emit_hit)) == keep_cnt_r)
    else $error("row finished with kept entries not emitted");
`endif

endmodule

@@ rtl/core/sparse_row_relative_drop_core.sv @@
// Top level of the sparse row relative drop core.
// Depends on srrd_pkg, srrd_ctrl, srrd_datapath (which holds srrd_ram).
//
// Usage:
//  - Input: an item is taken on a rising edge with start high and busy low.
//    in_has_entry marks a nonzero entry, in_row_end closes the row.
//  - Entries of an open row are taken one per cycle; busy stays low.
//  - When a non-empty row closes, busy rises while the block forms the
//    threshold, counts the kept entries in one pass over the row buffer
//    and emits them in a second pass, both through the single read port
//    of the row buffer.
//  - Results: out_strobe marks each beat for one cycle, in arrival order,
//    with out_last_of_row on the final beat of the row. The first beat
//    leaves in the emit pass, after the count pass, and later for each
//    dropped entry ahead of it.
//  - An empty row gives one marker beat the cycle after its item, busy low.
//  - Configuration: cfg_we writes cfg_data to register cfg_index (0 drop tolerance,
//    1 index base); the user writes only while the block is idle, the block does not enforce it.
//  - Reset (rst_n low, synchronous) empties the row, clears the running
//    kept count and the configuration registers. The receiver cannot stall the results.
module sparse_row_relative_drop_core #(
  parameter int MAX_ROW_ENTRIES = srrd_pkg::MaxRowEntries,
  parameter int COLUMN_BITS     = srrd_pkg::ColumnBits
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [srrd_pkg::CfgIndexBits-1:0]     cfg_index,
  input  logic [srrd_pkg::CfgDataBits-1:0]      cfg_data,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [COLUMN_BITS-1:0]                in_column_index,
  input  logic signed [srrd_pkg::ValueBits-1:0] in_entry_value,
  input  logic                                  in_has_entry,
  input  logic                                  in_row_end,
  output logic                                  out_strobe,
  output logic [COLUMN_BITS-1:0]                out_kept_column,
  output logic signed [srrd_pkg::ValueBits-1:0] out_kept_value,
  output logic                                  out_kept_valid,
  output logic                                  out_last_of_row,
  output logic [srrd_pkg::PtrBits-1:0]          out_row_end_pointer
);

  srrd_pkg::ctrl_cmd_t  cmd;
  srrd_pkg::dp_status_t status;

  srrd_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  srrd_datapath #(
    .MAX_ROW_ENTRIES (MAX_ROW_ENTRIES),
    .COLUMN_BITS     (COLUMN_BITS)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_column_index     (in_column_index),
    .in_entry_value      (in_entry_value),
    .in_has_entry        (in_has_entry),
    .in_row_end          (in_row_end),
    .out_strobe          (out_strobe),
    .out_kept_column     (out_kept_column),
    .out_kept_value      (out_kept_value),
    .out_kept_valid      (out_kept_valid),
    .out_last_of_row     (out_last_of_row),
    .out_row_end_pointer (out_row_end_pointer)
  );

endmodule
